// ===== sv/markov_stationary_distribution_defines.svh =====
// Assertion macros shared by the markov_stationary_distribution RTL
`ifndef MARKOV_STATIONARY_DISTRIBUTION_DEFINES_SVH
`define MARKOV_STATIONARY_DISTRIBUTION_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSD_ASSERT(lbl, clk, rst, prop, msg)
`define MSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/msd_pkg.sv =====
// Shared constants, types and tables for the stationary distribution block
package msd_pkg;

  localparam int MAX_STATES = 16;
  localparam int IDX_W      = $clog2(MAX_STATES);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int Q_W        = 48;
  localparam int IN_W       = 17;
  localparam int PI_W       = 25;

  localparam logic [CNT_W-1:0] N_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_STATES);

  localparam logic signed [Q_W-1:0] QONE = 48'sh0001_0000_0000;
  localparam logic signed [Q_W-1:0] QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [Q_W-1:0] QMIN = 48'sh8000_0000_0000;
  localparam logic [PI_W-1:0]       PI_MAX = 25'h100_0000;

  // register indexes
  localparam logic REG_N_STATES = 1'b0;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LD_A,
    OP_LD_B,
    OP_MUL,
    OP_ACC_CLR,
    OP_ACC_ONE,
    OP_NUM_ACC,
    OP_NUM_MSUB,
    OP_DIV,
    OP_STORE,
    OP_SUM_CLR,
    OP_SUM_ADD,
    OP_DIV_SUM,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ADDR_W-1:0] addr;
    logic              one;     // operand is 1.0 instead of memory data
    logic              acc_sub; // accumulate by saturating subtract
    logic              zero_m;  // minuend is 0.0 instead of memory data
    logic              diag;    // loaded entry sits on the diagonal
    logic              last;    // last load entry / last result
    logic [IDX_W-1:0]  idx;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } dp_stat_t;

  // round(2^32 / n), Q16.32 value of 1/n
  function automatic logic [32:0] recip_n(input logic [CNT_W-1:0] n);
    logic [32:0] u;
    unique case (n)
      5'd2:    u = 33'd2147483648;
      5'd3:    u = 33'd1431655765;
      5'd4:    u = 33'd1073741824;
      5'd5:    u = 33'd858993459;
      5'd6:    u = 33'd715827883;
      5'd7:    u = 33'd613566757;
      5'd8:    u = 33'd536870912;
      5'd9:    u = 33'd477218588;
      5'd10:   u = 33'd429496730;
      5'd11:   u = 33'd390451572;
      5'd12:   u = 33'd357913941;
      5'd13:   u = 33'd330382100;
      5'd14:   u = 33'd306783378;
      5'd15:   u = 33'd286331153;
      5'd16:   u = 33'd268435456;
      default: u = 33'd0;
    endcase
    return u;
  endfunction

endpackage

// ===== sv/markov_stationary_distribution.sv =====
// Top level: stationary distribution of a Markov chain by in-place LU inversion
//
//  channel  | dir | handshake                  | payload
//  s_*      | in  | s_tvalid / s_tready        | s_tdata[16:0] prob_q16
//  m_*      | out | m_tvalid / m_tready        | m_tdata pi_q24, state_index; tuser singular; tlast
//  apb      | in  | psel & penable & pwrite    | addr 0: n_states[4:0]
//
// Loading takes one entry a cycle unless a register write restarts it, n*n entries per run.
// The last entry starts the inversion: one 24x24 multiplier used four times per
// multiply-accumulate (~n^3 of them) and a radix-2 divider for each dividing
// element (~n^2 of them); then n column sums, each divided by n. Input is not taken
// until all n results are issued into the output register. Reset (rst, synchronous)
// clears control state only; a stalled m_tready holds the result and pauses the sequencer.
module markov_stationary_distribution (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [16:0] prob_q16
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [24:0] pi_q24, [28:25] state_index
  output logic        m_tuser,   // [0] singular
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [msd_pkg::CNT_W-1:0] n_states, n;
  logic                      cfg_wr;
  msd_pkg::dp_cmd_t          cmd;
  msd_pkg::dp_stat_t         stat;
  logic [msd_pkg::PI_W-1:0]  out_pi;
  logic [msd_pkg::IDX_W-1:0] out_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == msd_pkg::REG_N_STATES);
  assign prdata = {{(32-msd_pkg::CNT_W){1'b0}}, n_states};

  always_ff @(posedge clk) begin
    if (rst) begin
      n_states <= msd_pkg::CNT_W'(2);
    end else if (cfg_wr) begin
      n_states <= pwdata[msd_pkg::CNT_W-1:0];
    end
  end

  assign n = (n_states < msd_pkg::N_MIN) ? msd_pkg::N_MIN :
             (n_states > msd_pkg::N_MAX) ? msd_pkg::N_MAX : n_states;

  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .n        (n),
    .cfg_clr  (cfg_wr),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .n         (n),
    .prob      (s_tdata[msd_pkg::IN_W-1:0]),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pi    (out_pi),
    .out_idx   (out_idx),
    .out_sing  (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'd0, out_idx, out_pi};

endmodule

// ===== sv/msd_ctrl.sv =====
// Sequencer: load counting, LU inversion loop nest, column sums and result issue
`include "markov_stationary_distribution_defines.svh"

module msd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [msd_pkg::CNT_W-1:0]    n,
  input  logic                         cfg_clr,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  msd_pkg::dp_stat_t            stat,
  output msd_pkg::dp_cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_MA, S_MB, S_MC, S_MD, S_MW,
    S_FA, S_FB, S_FC, S_FD, S_FW, S_ST,
    S_SC, S_SA, S_SB, S_SD, S_SW, S_SO
  } state_t;

  // L: lower factor, U: upper factor, LI/UI: triangular inverses, MUL: product
  typedef enum logic [2:0] {
    PH_P0, PH_L, PH_U, PH_LI, PH_UI, PH_MUL, PH_SUM
  } phase_t;

  state_t                     state;
  phase_t                     phase, phase_next;
  logic [msd_pkg::CNT_W-1:0]  i, j, k, i_next, j_next;
  logic [msd_pkg::CNT_W-1:0]  ld_row, ld_col;
  logic [msd_pkg::CNT_W-1:0]  n_m1, k_lo, k_hi;
  logic [msd_pkg::ADDR_W-1:0] a_addr, b_addr, m_addr, d_addr, dst_addr;
  logic                       a_one, b_one, use_msub, zero_m, use_div;
  logic                       take;

  function automatic logic [msd_pkg::ADDR_W-1:0] ad(input logic [msd_pkg::CNT_W-1:0] r,
                                                   input logic [msd_pkg::CNT_W-1:0] c);
    return {r[msd_pkg::IDX_W-1:0], c[msd_pkg::IDX_W-1:0]};
  endfunction

  assign n_m1     = n - 1'b1;
  // a register write restarts the load, so no request is taken in that cycle
  assign in_ready = (state == S_LOAD) && !cfg_clr;
  assign take     = in_valid && in_ready;

  // loop bounds, operand and finish addresses of the current element
  always_comb begin
    k_lo = '0; k_hi = '0;
    a_addr = '0; b_addr = '0; a_one = 1'b0; b_one = 1'b0;
    m_addr = '0; d_addr = '0; dst_addr = '0;
    use_msub = 1'b0; zero_m = 1'b0; use_div = 1'b0;
    unique case (phase)
      PH_P0: begin
        use_msub = 1'b1; use_div = 1'b1;
        m_addr = ad('0, i); d_addr = ad('0, '0); dst_addr = ad('0, i);
      end
      PH_L: begin
        k_hi = i;
        a_addr = ad(j, k); b_addr = ad(k, i);
        use_msub = 1'b1; m_addr = ad(j, i); dst_addr = ad(j, i);
      end
      PH_U: begin
        k_hi = i;
        a_addr = ad(i, k); b_addr = ad(k, j);
        use_msub = 1'b1; use_div = 1'b1;
        m_addr = ad(i, j); d_addr = ad(i, i); dst_addr = ad(i, j);
      end
      PH_LI: begin
        k_lo = i; k_hi = j;
        a_addr = ad(j, k); b_addr = ad(k, i);
        use_div = 1'b1; d_addr = ad(j, j); dst_addr = ad(j, i);
      end
      PH_UI: begin
        k_lo = i; k_hi = j;
        a_addr = ad(k, j); b_addr = ad(i, k); b_one = (i == k);
        use_msub = 1'b1; zero_m = 1'b1; dst_addr = ad(i, j);
      end
      PH_MUL: begin
        k_lo = (i > j) ? i : j; k_hi = n;
        a_addr = ad(j, k); a_one = (j == k); b_addr = ad(k, i);
        dst_addr = ad(j, i);
      end
      PH_SUM: begin
        m_addr = ad(j, i);
      end
      default: ;
    endcase
  end

  // next element of the loop nest
  always_comb begin
    phase_next = phase; i_next = i; j_next = j + 1'b1;
    unique case (phase)
      PH_P0: begin
        i_next = i + 1'b1;
        if (i == n_m1) begin
          phase_next = PH_L; i_next = msd_pkg::CNT_W'(1); j_next = msd_pkg::CNT_W'(1);
        end
      end
      PH_L: begin
        if (j == n_m1) begin
          if (i == n_m1) begin
            phase_next = PH_LI; i_next = '0; j_next = '0;
          end else begin
            phase_next = PH_U; j_next = i + 1'b1;
          end
        end
      end
      PH_U: begin
        if (j == n_m1) begin
          phase_next = PH_L; i_next = i + 1'b1; j_next = i + 1'b1;
        end
      end
      PH_LI: begin
        if (j == n_m1) begin
          if (i == n_m1) begin
            phase_next = PH_UI; i_next = '0; j_next = msd_pkg::CNT_W'(1);
          end else begin
            i_next = i + 1'b1; j_next = i + 1'b1;
          end
        end
      end
      PH_UI: begin
        if (j == n_m1) begin
          if (i + msd_pkg::CNT_W'(2) > n_m1) begin
            phase_next = PH_MUL; i_next = '0; j_next = '0;
          end else begin
            i_next = i + 1'b1; j_next = i + msd_pkg::CNT_W'(2);
          end
        end
      end
      PH_MUL: begin
        if (j == n_m1) begin
          if (i == n_m1) begin
            phase_next = PH_SUM; i_next = '0; j_next = '0;
          end else begin
            i_next = i + 1'b1; j_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      phase  <= PH_P0;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      ld_row <= '0;
      ld_col <= '0;
    end else begin
      if (cfg_clr) begin
        ld_row <= '0;
        ld_col <= '0;
      end
      unique case (state)
        S_LOAD: begin
          if (take) begin
            if (ld_col == n_m1) begin
              ld_col <= '0;
              if (ld_row == n_m1) begin
                ld_row <= '0;
                phase  <= PH_P0;
                i      <= msd_pkg::CNT_W'(1);
                j      <= '0;
                state  <= S_INIT;
              end else begin
                ld_row <= ld_row + 1'b1;
              end
            end else begin
              ld_col <= ld_col + 1'b1;
            end
          end
        end
        S_INIT: begin
          k     <= k_lo;
          state <= (k_lo < k_hi) ? S_MA : S_FA;
        end
        S_MA: state <= S_MB;
        S_MB: state <= S_MC;
        S_MC: state <= S_MD;
        S_MD: state <= S_MW;
        S_MW: begin
          if (!stat.busy) begin
            k     <= k + 1'b1;
            state <= (k + 1'b1 < k_hi) ? S_MA : S_FA;
          end
        end
        S_FA: state <= S_FB;
        S_FB: state <= use_div ? S_FC : S_ST;
        S_FC: state <= S_FD;
        S_FD: state <= S_FW;
        S_FW: if (!stat.busy) state <= S_ST;
        S_ST: begin
          phase <= phase_next;
          i     <= i_next;
          j     <= j_next;
          state <= (phase_next == PH_SUM) ? S_SC : S_INIT;
        end
        S_SC: begin
          j     <= '0;
          state <= S_SA;
        end
        S_SA: state <= S_SB;
        S_SB: begin
          if (j == n_m1) begin
            state <= S_SD;
          end else begin
            j     <= j + 1'b1;
            state <= S_SA;
          end
        end
        S_SD: state <= S_SW;
        S_SW: if (!stat.busy) state <= S_SO;
        S_SO: begin
          if (!stat.out_valid) begin
            if (i == n_m1) begin
              state <= S_LOAD;
            end else begin
              i     <= i + 1'b1;
              state <= S_SC;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd = '{op: msd_pkg::OP_NOP, addr: '0, one: 1'b0, acc_sub: 1'b0, zero_m: 1'b0,
            diag: 1'b0, last: 1'b0, idx: '0};
    unique case (state)
      S_LOAD: begin
        cmd.op   = take ? msd_pkg::OP_LOAD : msd_pkg::OP_NOP;
        cmd.addr = ad(ld_row, ld_col);
        cmd.diag = (ld_row == ld_col);
        cmd.last = (ld_row == n_m1) && (ld_col == n_m1);
      end
      S_INIT: cmd.op = ((phase == PH_LI) && (i == j)) ? msd_pkg::OP_ACC_ONE
                                                     : msd_pkg::OP_ACC_CLR;
      S_MA: cmd.addr = a_addr;
      S_MB: begin
        cmd.op = msd_pkg::OP_LD_A; cmd.one = a_one; cmd.addr = b_addr;
      end
      S_MC: begin
        cmd.op = msd_pkg::OP_LD_B; cmd.one = b_one;
      end
      S_MD: begin
        cmd.op = msd_pkg::OP_MUL; cmd.acc_sub = (phase == PH_LI);
      end
      S_FA: cmd.addr = m_addr;
      S_FB: begin
        cmd.op     = use_msub ? msd_pkg::OP_NUM_MSUB : msd_pkg::OP_NUM_ACC;
        cmd.zero_m = zero_m;
        cmd.addr   = d_addr;
      end
      S_FC: cmd.op = msd_pkg::OP_LD_B;
      S_FD: cmd.op = msd_pkg::OP_DIV;
      S_ST: begin
        cmd.op = msd_pkg::OP_STORE; cmd.addr = dst_addr;
      end
      S_SC: cmd.op = msd_pkg::OP_SUM_CLR;
      S_SA: cmd.addr = m_addr;
      S_SB: cmd.op = msd_pkg::OP_SUM_ADD;
      S_SD: cmd.op = msd_pkg::OP_DIV_SUM;
      S_SO: begin
        cmd.op   = stat.out_valid ? msd_pkg::OP_NOP : msd_pkg::OP_OUT;
        cmd.idx  = i[msd_pkg::IDX_W-1:0];
        cmd.last = (i == n_m1);
      end
      default: ;
    endcase
  end

  `MSD_ASSERT(a_k_in_range, clk, rst, (state == S_MA) |-> (k < k_hi), "k past loop bound")
  `MSD_ASSERT(a_load_pos, clk, rst, (state == S_LOAD) |-> ((ld_row < n) && (ld_col < n)), "bad load")
  `MSD_ASSERT(a_store_idle, clk, rst, (state == S_ST) |-> !stat.busy, "store while arithmetic busy")

endmodule

// ===== sv/msd_dp.sv =====
// Datapath: matrix memory, shared 24x24 multiplier, radix-2 divider, accumulators, result register
`include "markov_stationary_distribution_defines.svh"

module msd_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  msd_pkg::dp_cmd_t               cmd,
  input  logic [msd_pkg::CNT_W-1:0]      n,
  input  logic [msd_pkg::IN_W-1:0]       prob,
  output msd_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [msd_pkg::PI_W-1:0]       out_pi,
  output logic [msd_pkg::IDX_W-1:0]      out_idx,
  output logic                           out_sing,
  output logic                           out_last
);

  localparam int QW = msd_pkg::Q_W;

  logic [QW-1:0]        mem [msd_pkg::MAX_STATES*msd_pkg::MAX_STATES];
  logic [QW-1:0]        rdata;
  logic signed [QW-1:0] acc, opa, opb, num, prod;
  logic signed [52:0]   sum;
  logic                 sing;
  logic [msd_pkg::PI_W-1:0] pv;

  // multiplier
  logic [2:0]           mstep;
  logic                 m_neg, m_sub;
  logic [QW-1:0]        ua, ub, hh, low, mres;
  logic [48:0]          mid, lowsum, q49, mag;
  logic [23:0]          mx, my;

  // divider
  logic [6:0]           dcnt;
  logic [79:0]          dvd;
  logic [QW-1:0]        dvs, rem, dq;
  logic                 dbig, dneg, dmode;
  logic [48:0]          r2, r2_sub;
  logic                 ge;
  logic [39:0]          qs;

  logic signed [49:0]   load_v;
  logic signed [48:0]   acc_v, msub_v;
  logic signed [QW-1:0] m_val;

  function automatic logic [QW-1:0] qabs(input logic signed [QW-1:0] a);
    return a[QW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic signed [QW-1:0] qsigned(input logic [48:0] m, input logic neg);
    logic signed [QW-1:0] r;
    if (neg) begin
      if (m >= 49'h0_8000_0000_0000) r = msd_pkg::QMIN;
      else                            r = -$signed(m[QW-1:0]);
    end else begin
      if (m > 49'h0_7FFF_FFFF_FFFF)   r = msd_pkg::QMAX;
      else                            r = m[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] sat49(input logic signed [48:0] v);
    logic signed [QW-1:0] r;
    if (v[48] != v[47]) r = v[48] ? msd_pkg::QMIN : msd_pkg::QMAX;
    else                r = v[QW-1:0];
    return r;
  endfunction

  always_comb begin
    load_v = $signed({17'd0, msd_pkg::recip_n(n)})
           - $signed({16'd0, 1'b0, prob, 16'd0})
           + (cmd.diag ? $signed({2'b00, msd_pkg::QONE}) : 50'sd0);
  end

  // partial product select: hh, then the two cross terms, then low
  always_comb begin
    unique case (mstep)
      3'd1:    begin mx = ua[47:24]; my = ub[47:24]; end
      3'd2:    begin mx = ua[47:24]; my = ub[23:0];  end
      3'd3:    begin mx = ua[23:0];  my = ub[47:24]; end
      default: begin mx = ua[23:0];  my = ub[23:0];  end
    endcase
    mres = mx * my;
  end

  assign lowsum = {17'd0, mid[7:0], 24'd0} + {1'b0, low};
  assign q49    = {hh[32:0], 16'd0} + {8'd0, mid[48:8]} + {32'd0, lowsum[48:32]};
  assign mag    = (|hh[47:31]) ? 49'h1_0000_0000_0000 : q49;
  assign acc_v  = m_sub ? ($signed({acc[47], acc}) - $signed({prod[47], prod}))
                        : ($signed({acc[47], acc}) + $signed({prod[47], prod}));
  assign m_val  = cmd.zero_m ? '0 : $signed(rdata);
  assign msub_v = $signed({m_val[47], m_val}) - $signed({acc[47], acc});

  assign r2     = {rem, dvd[79]};
  assign r2_sub = r2 - {1'b0, dvs};
  assign ge     = (r2 >= {1'b0, dvs});
  assign qs     = dq[47:8];

  assign stat.busy      = (mstep != 3'd0) || (dcnt != 7'd0);
  assign stat.out_valid = out_valid;

  // matrix store, row-major on a MAX_STATES pitch
  always_ff @(posedge clk) begin
    if (cmd.op == msd_pkg::OP_LOAD)  mem[cmd.addr] <= load_v[QW-1:0];
    if (cmd.op == msd_pkg::OP_STORE) mem[cmd.addr] <= num;
    rdata <= mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstep     <= '0;
      dcnt      <= '0;
      sing      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        msd_pkg::OP_LOAD:     if (cmd.last) sing <= 1'b0;
        msd_pkg::OP_LD_A:     opa <= cmd.one ? msd_pkg::QONE : $signed(rdata);
        msd_pkg::OP_LD_B:     opb <= cmd.one ? msd_pkg::QONE : $signed(rdata);
        msd_pkg::OP_ACC_CLR:  acc <= '0;
        msd_pkg::OP_ACC_ONE:  acc <= msd_pkg::QONE;
        msd_pkg::OP_NUM_ACC:  num <= acc;
        msd_pkg::OP_NUM_MSUB: num <= sat49(msub_v);
        msd_pkg::OP_SUM_CLR:  sum <= '0;
        msd_pkg::OP_SUM_ADD:  sum <= sum + {{5{rdata[47]}}, rdata};
        msd_pkg::OP_MUL: begin
          ua    <= qabs(opa);
          ub    <= qabs(opb);
          m_neg <= opa[47] ^ opb[47];
          m_sub <= cmd.acc_sub;
          mstep <= 3'd1;
        end
        msd_pkg::OP_DIV: begin
          if (opb == '0) begin
            sing <= 1'b1;
            num  <= '0;
          end else begin
            dvd   <= {qabs(num), 32'd0};
            dvs   <= qabs(opb);
            dneg  <= num[47] ^ opb[47];
            dmode <= 1'b0;
            rem   <= '0;
            dq    <= '0;
            dbig  <= 1'b0;
            dcnt  <= 7'd81;
          end
        end
        msd_pkg::OP_DIV_SUM: begin
          if (!sum[52] && (sum != '0) && !sing) begin
            dvd   <= {27'd0, sum};
            dvs   <= {{(QW-msd_pkg::CNT_W){1'b0}}, n};
            dneg  <= 1'b0;
            dmode <= 1'b1;
            rem   <= '0;
            dq    <= '0;
            dbig  <= 1'b0;
            dcnt  <= 7'd81;
          end else begin
            pv <= '0;
          end
        end
        msd_pkg::OP_OUT: begin
          out_valid <= 1'b1;
          out_pi    <= pv;
          out_idx   <= cmd.idx;
          out_last  <= cmd.last;
          out_sing  <= sing;
        end
        default: ;
      endcase

      // multiply-accumulate sequence
      case (mstep)
        3'd1: begin hh <= mres; mstep <= 3'd2; end
        3'd2: begin mid <= {1'b0, mres}; mstep <= 3'd3; end
        3'd3: begin mid <= mid + {1'b0, mres}; mstep <= 3'd4; end
        3'd4: begin low <= mres; mstep <= 3'd5; end
        3'd5: begin prod <= qsigned(mag, m_neg); mstep <= 3'd6; end
        3'd6: begin acc <= sat49(acc_v); mstep <= 3'd0; end
        default: ;
      endcase

      // restoring divider, one quotient bit a cycle
      if (dcnt > 7'd1) begin
        rem <= ge ? r2_sub[QW-1:0] : r2[QW-1:0];
        if (dq[47]) dbig <= 1'b1;
        else        dq   <= {dq[46:0], ge};
        dvd  <= {dvd[78:0], 1'b0};
        dcnt <= dcnt - 1'b1;
      end else if (dcnt == 7'd1) begin
        if (dmode) begin
          if (dbig || (qs > 40'd16777216)) pv <= msd_pkg::PI_MAX;
          else                             pv <= qs[msd_pkg::PI_W-1:0];
        end else begin
          num <= qsigned(dbig ? 49'h1_0000_0000_0000 : {1'b0, dq}, dneg);
        end
        dcnt <= 7'd0;
      end
    end
  end

  `MSD_ASSERT(a_one_unit, clk, rst, !((mstep != 3'd0) && (dcnt != 7'd0)), "multiplier and divider overlap")
  `MSD_ASSERT(a_mul_start, clk, rst, (cmd.op == msd_pkg::OP_MUL) |-> !stat.busy, "multiply started while busy")
  `MSD_ASSERT(a_out_free, clk, rst, (cmd.op == msd_pkg::OP_OUT) |-> !out_valid, "result register overwritten")

endmodule

// ===== test/tb_markov_stationary_distribution.sv =====
// Testbench for markov_stationary_distribution: matrix loads, checked pi results per state
module tb_markov_stationary_distribution;

  localparam int WDOG_LIMIT = 400000;
  localparam int SETTLE     = 40;
  localparam longint QONE_L = 64'sd1 <<< 32;
  localparam longint QMAX_L = (64'sd1 <<< 47) - 1;
  localparam longint QMIN_L = -(64'sd1 <<< 47);

  typedef struct {
    logic [msd_pkg::PI_W-1:0]  pi;
    logic [msd_pkg::IDX_W-1:0] idx;
    logic                      sing;
    logic                      last;
  } pi_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  markov_stationary_distribution u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // predictor state
  longint     mat [msd_pkg::MAX_STATES*msd_pkg::MAX_STATES];
  int         loaded;
  logic [4:0] n_reg;
  bit         zero_pivot;
  pi_result_t pi_expected[$];

  int errors;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_left;
  int quiet_cycles;

  // ---------------- fixed-point predictor ----------------
  function automatic longint sat_q(longint v);
    if (v > QMAX_L) return QMAX_L;
    if (v < QMIN_L) return QMIN_L;
    return v;
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    if (neg) begin
      if (m >= (64'd1 << 47)) return QMIN_L;
      return -longint'(m);
    end
    if (m > longint'(QMAX_L)) return QMAX_L;
    return longint'(m);
  endfunction

  function automatic longint unsigned mag(longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, ah, al, bh, bl, hh, mid, low, q;
    neg = (a < 0) != (b < 0);
    ua = mag(a);
    ub = mag(b);
    ah = ua >> 24; al = ua & 64'hFFFFFF;
    bh = ub >> 24; bl = ub & 64'hFFFFFF;
    hh = ah * bh;
    if (hh >= (64'd1 << 31)) return apply_sign(64'd1 << 48, neg);
    mid = ah * bl + al * bh;
    low = al * bl;
    q = (hh << 16) + (mid >> 8) + ((((mid & 64'hFF) << 24) + low) >> 32);
    return apply_sign(q, neg);
  endfunction

  function automatic longint q_div(longint x, longint d);
    bit neg, big;
    longint unsigned ux, ud, r, q, bt, qb;
    neg = (x < 0) != (d < 0);
    ux = mag(x);
    ud = mag(d);
    r = 0; q = 0; big = 0;
    if (d == 0) begin
      zero_pivot = 1;
      return 0;
    end
    for (int b = 79; b >= 0; b--) begin
      bt = (b >= 32) ? ((ux >> (b - 32)) & 64'd1) : 64'd0;
      qb = 0;
      r = (r << 1) | bt;
      if (r >= ud) begin
        r -= ud;
        qb = 1;
      end
      if (q >= (64'd1 << 47)) big = 1;
      else q = (q << 1) | qb;
    end
    if (big) q = 64'd1 << 48;
    return apply_sign(q, neg);
  endfunction

  function automatic void lu_invert(int n);
    longint s, x;
    for (int i = 1; i < n; i++) mat[i] = q_div(mat[i], mat[0]);
    for (int i = 1; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        s = 0;
        for (int k = 0; k < i; k++) s = sat_q(s + q_mul(mat[j*n+k], mat[k*n+i]));
        mat[j*n+i] = sat_q(mat[j*n+i] - s);
      end
      if (i != n - 1)
        for (int j = i + 1; j < n; j++) begin
          s = 0;
          for (int k = 0; k < i; k++) s = sat_q(s + q_mul(mat[i*n+k], mat[k*n+j]));
          mat[i*n+j] = q_div(sat_q(mat[i*n+j] - s), mat[i*n+i]);
        end
    end
    // invert L
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++) begin
        x = QONE_L;
        if (i != j) begin
          x = 0;
          for (int k = i; k < j; k++) x = sat_q(x - q_mul(mat[j*n+k], mat[k*n+i]));
        end
        mat[j*n+i] = q_div(x, mat[j*n+j]);
      end
    // invert unit upper U
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        s = 0;
        for (int k = i; k < j; k++)
          s = sat_q(s + q_mul(mat[k*n+j], (i == k) ? QONE_L : mat[i*n+k]));
        mat[i*n+j] = sat_q(-s);
      end
    // inv(U) * inv(L)
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        s = 0;
        for (int k = (i > j) ? i : j; k < n; k++)
          s = sat_q(s + q_mul((j == k) ? QONE_L : mat[j*n+k], mat[k*n+i]));
        mat[j*n+i] = s;
      end
  endfunction

  function automatic int eff_states();
    if (n_reg < 2) return 2;
    if (n_reg > msd_pkg::MAX_STATES) return msd_pkg::MAX_STATES;
    return int'(n_reg);
  endfunction

  // one accepted probability: store A entry, invert when the matrix is full
  function automatic void predict_entry(logic [16:0] p);
    int n, row, col;
    longint u, s;
    longint unsigned pv;
    pi_result_t e;
    n = eff_states();
    if (loaded >= n * n) loaded = 0;
    u = (QONE_L + n / 2) / n;
    row = loaded / n;
    col = loaded % n;
    mat[loaded] = u - (longint'(p) <<< 16) + ((row == col) ? QONE_L : 0);
    loaded++;
    if (loaded < n * n) return;
    loaded = 0;
    zero_pivot = 0;
    lu_invert(n);
    for (int c = 0; c < n; c++) begin
      s = 0;
      pv = 0;
      for (int r = 0; r < n; r++) s += mat[r*n+c];
      if (s > 0 && !zero_pivot) begin
        pv = (longint'(s) / n) >> 8;
        if (pv > (64'd1 << 24)) pv = 64'd1 << 24;
      end
      e.pi = pv[msd_pkg::PI_W-1:0];
      e.idx = c[msd_pkg::IDX_W-1:0];
      e.sing = zero_pivot;
      e.last = (c == n - 1);
      pi_expected.push_back(e);
    end
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    pi_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pi_expected.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        e = pi_expected.pop_front();
        if (m_tdata[24:0] !== e.pi || m_tdata[28:25] !== e.idx ||
            m_tuser !== e.sing || m_tlast !== e.last) begin
          $display("%0t: mismatch expected pi=%h idx=%0d sing=%b last=%b", $time,
                   e.pi, e.idx, e.sing, e.last);
          $display("%0t:          actual   pi=%h idx=%0d sing=%b last=%b", $time,
                   m_tdata[24:0], m_tdata[28:25], m_tuser, m_tlast);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  task automatic send_prob(logic [16:0] p);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_entry(p);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (pi_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_n_states(logic [4:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(msd_pkg::REG_N_STATES) << 2;
    pwdata <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    n_reg = v;
    loaded = 0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one row of P: well formed rows sum to exactly 1.0, noisy rows are arbitrary
  task automatic send_row(int n, bit noisy);
    int w[msd_pkg::MAX_STATES];
    int sum, acc;
    logic [16:0] p;
    sum = 0;
    for (int c = 0; c < n; c++) begin
      w[c] = ($urandom_range(7) == 0) ? 0 : $urandom_range(1000);
      sum += w[c];
    end
    if (sum == 0) begin
      w[0] = 1;
      sum = 1;
    end
    acc = 0;
    for (int c = 0; c < n; c++) begin
      if (noisy) p = $urandom_range(65536);
      else if (c == n - 1) p = 17'(65536 - acc);
      else p = 17'((w[c] * 65536) / sum);
      acc += p;
      send_prob(p);
    end
  endtask

  task automatic send_matrix(int n, bit noisy);
    for (int r = 0; r < n; r++) send_row(n, noisy);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    // n=2 at reset: zero entries, then identity P, which makes A = U: zero pivot
    repeat (4) send_prob(17'd0);
    send_prob(17'd65536); send_prob(17'd0); send_prob(17'd0); send_prob(17'd65536);
    // every row puts all its weight on state 0
    send_prob(17'd65536); send_prob(17'd0); send_prob(17'd65536); send_prob(17'd0);
    // mixed extremes, one entry above 1.0 at the full input width
    send_prob(17'h0FFFF); send_prob(17'h00001); send_prob(17'h1FFFF); send_prob(17'h0AAAA);
    stop_sending();
    wait_results();
    // partial load discarded by a register write
    write_n_states(5'd3);
    repeat (4) send_prob(17'd21845);
    stop_sending();
    wait_results();
    write_n_states(5'd3);
    repeat (9) send_prob(17'd21845);
    stop_sending();
    wait_results();
    // below range acts as two
    write_n_states(5'd0);
    send_prob(17'd30000); send_prob(17'd35536); send_prob(17'd40000); send_prob(17'd25536);
    stop_sending();
    wait_results();
    write_n_states(5'd1);
    write_n_states(5'd17);
    write_n_states(5'd2);
  endtask

  task automatic test_largest();
    // above range acts as sixteen
    write_n_states(5'd31);
    send_matrix(16, 1'b0);
    stop_sending();
    wait_results();
    write_n_states(5'd16);
    wait_results();
  endtask

  task automatic test_random(int idle, int stall, int items);
    int sent, n;
    src_idle_pct = idle;
    snk_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(2, 5);
      write_n_states(5'(n));
      send_matrix(n, $urandom_range(4) == 0);
      sent += n * n;
      // random data exercise without draining between runs of the same size
      if ($urandom_range(1)) begin
        send_matrix(n, 1'b0);
        sent += n * n;
      end
      stop_sending();
      wait_results();
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    write_n_states(5'd2);
    hold_left = 3000;
    repeat (4) send_matrix(2, 1'b0);
    stop_sending();
    wait_results();
  endtask

  task automatic test_pause_between_runs();
    src_idle_pct = 15;
    snk_stall_pct = 15;
    write_n_states(5'd3);
    repeat (3) begin
      send_matrix(3, 1'b0);
      s_tvalid <= 1'b0;
      while (pi_expected.size() != 0) @(posedge clk);
    end
    stop_sending();
    wait_results();
  endtask

  initial begin
    errors = 0;
    loaded = 0;
    n_reg = 5'd2;
    hold_left = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_largest();
    test_backpressure();
    test_pause_between_runs();
    test_random(0, 0, 8);
    test_random(75, 0, 8);
    test_random(0, 75, 8);
    test_random(15, 15, 8);
    stop_sending();
    wait_results();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/msd_pkg.sv
sv/msd_ctrl.sv
sv/msd_dp.sv
sv/markov_stationary_distribution.sv
test/tb_markov_stationary_distribution.sv
